@@ src/polyline_rect_clip_filter_macros.svh @@
// Assertion macros for the polyline clip filter.
// No dependencies; included by the files that carry assertions.
`ifndef POLYLINE_RECT_CLIP_FILTER_MACROS_SVH
`define POLYLINE_RECT_CLIP_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define PLRC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PLRC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLRC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PLRC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/plrc_pkg.sv @@
// Shared types, codes and helpers of the polyline clip filter.
// No dependencies; the front, back, top and testbench files take names from here by scope.
package plrc_pkg;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned OpW      = CoordW + 2;
  localparam int unsigned ProdW    = 2 * CoordW + 3;
  localparam int unsigned NumEdges = 4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [OpW-1:0]    op_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_END  = 1'b1
  } req_type_e;

  typedef enum logic {
    EVT_START  = 1'b0,
    EVT_APPEND = 1'b1
  } event_kind_e;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_e;

  typedef enum logic [1:0] {
    CMD_END  = 2'd0,
    CMD_EMIT = 2'd1,
    CMD_TEST = 2'd2
  } cmd_cls_e;

  typedef struct packed {
    req_type_e req_type;
    coord_t    point_x;
    coord_t    point_y;
  } in_item_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic        has_point;
    coord_t      out_x;
    coord_t      out_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } area_t;

  typedef struct packed {
    cmd_cls_e cls;
    logic     has_prev;
    coord_t   prev_x;
    coord_t   prev_y;
    coord_t   cur_x;
    coord_t   cur_y;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_wr_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_wr_t;

  function automatic diff_t coord_sub(coord_t a, coord_t b);
    return DiffW'(a) - DiffW'(b);
  endfunction

endpackage

@@ src/polyline_rect_clip_filter.sv @@
// polyline_rect_clip_filter: top level joining plrc_front, plrc_back and two plrc_fifo queues.
// Throughput: one request per cycle without edge test, once the line is started and while the result
// queue has room; a request needing the edge test holds the back part through the four-step edge
// loop on one shared multiplier set.
// Reset: asynchronous; clears rectangle, held point, line state and both queues. No clear pass.
`include "polyline_rect_clip_filter_macros.svh"
module polyline_rect_clip_filter #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  plrc_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output plrc_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  plrc_pkg::coord_t    cfg_data_i
);

  localparam int unsigned CmdW = $bits(plrc_pkg::cmd_t);
  localparam int unsigned OutW = $bits(plrc_pkg::out_item_t);

  plrc_pkg::area_t   area;
  plrc_pkg::cmd_wr_t cmd_wr;
  plrc_pkg::cmd_t    cmd;
  plrc_pkg::out_wr_t out_wr;
  logic [CmdW-1:0]   cmd_raw;
  logic [OutW-1:0]   out_raw;
  logic              cmd_full, cmd_empty, cmd_pop;
  logic              out_full;
  logic              line_started;
  logic              start_wr, start_ok;

  assign full       = cmd_full;
  assign cmd        = plrc_pkg::cmd_t'(cmd_raw);
  assign out_item_o = plrc_pkg::out_item_t'(out_raw);
  assign start_wr   = out_wr.valid && (out_wr.item.event_kind == plrc_pkg::EVT_START);
  assign start_ok   = !line_started && !out_wr.item.last && !out_wr.item.has_point;

  plrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .q_full_i    (cmd_full),
    .cmd_wr_o    (cmd_wr),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .area_o      (area)
  );

  plrc_fifo #(
    .Width (CmdW),
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr.valid),
    .wdata_i (cmd_wr.cmd),
    .full_o  (cmd_full),
    .rd_i    (cmd_pop),
    .rdata_o (cmd_raw),
    .empty_o (cmd_empty)
  );

  plrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .area_i         (area),
    .cmd_valid_i    (!cmd_empty),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .out_full_i     (out_full),
    .out_wr_o       (out_wr),
    .line_started_o (line_started)
  );

  plrc_fifo #(
    .Width (OutW),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr.valid),
    .wdata_i (out_wr.item),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (out_raw),
    .empty_o (empty)
  );

  `PLRC_ASSERT_IMP(a_cmd_room, clk_i, rst_ni, cmd_wr.valid, !cmd_full, "request queue overrun")
  `PLRC_ASSERT_IMP(a_out_room, clk_i, rst_ni, out_wr.valid, !out_full, "result queue overrun")
  `PLRC_ASSERT_IMP(a_start_once, clk_i, rst_ni, start_wr, start_ok, "bad start event")
  `PLRC_ASSERT_NXT(a_start_marks, clk_i, rst_ni, start_wr, line_started, "line not marked started")

endmodule

@@ src/plrc_fifo.sv @@
// Generic register queue used for requests and for results.
// No dependencies; Depth of two or more entries.
module plrc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/plrc_front.sv @@
// Front part: clip rectangle registers, held previous point, request classification.
// Depends on plrc_pkg.
module plrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  plrc_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output plrc_pkg::cmd_wr_t   cmd_wr_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  plrc_pkg::coord_t    cfg_data_i,
  output plrc_pkg::area_t     area_o
);

  plrc_pkg::area_t  area_q, area_d;
  plrc_pkg::coord_t prev_x_q, prev_x_d;
  plrc_pkg::coord_t prev_y_q, prev_y_d;
  logic             seen_first_q, seen_first_d;
  logic             accept, is_end, prev_in, cur_in;

  function automatic logic in_area(plrc_pkg::coord_t x, plrc_pkg::coord_t y,
                                   plrc_pkg::area_t a);
    return (x >= a.left) && (x <= a.right) && (y >= a.top) && (y <= a.bottom);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign area_o      = area_q;
  assign accept      = push_i && !q_full_i;
  assign is_end      = (in_item_i.req_type == plrc_pkg::REQ_END);
  assign prev_in     = in_area(prev_x_q, prev_y_q, area_q);
  assign cur_in      = in_area(in_item_i.point_x, in_item_i.point_y, area_q);

  always_comb begin
    area_d = area_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (plrc_pkg::reg_idx_e'(cfg_index_i))
        plrc_pkg::REG_LEFT:   area_d.left   = cfg_data_i;
        plrc_pkg::REG_TOP:    area_d.top    = cfg_data_i;
        plrc_pkg::REG_RIGHT:  area_d.right  = cfg_data_i;
        plrc_pkg::REG_BOTTOM: area_d.bottom = cfg_data_i;
      endcase
    end
  end

  always_comb begin
    cmd_wr_o.valid        = 1'b0;
    cmd_wr_o.cmd.cls      = plrc_pkg::CMD_TEST;
    cmd_wr_o.cmd.has_prev = seen_first_q;
    cmd_wr_o.cmd.prev_x   = prev_x_q;
    cmd_wr_o.cmd.prev_y   = prev_y_q;
    cmd_wr_o.cmd.cur_x    = in_item_i.point_x;
    cmd_wr_o.cmd.cur_y    = in_item_i.point_y;
    prev_x_d              = prev_x_q;
    prev_y_d              = prev_y_q;
    seen_first_d          = seen_first_q;
    if (accept) begin
      priority if (is_end) begin
        cmd_wr_o.valid   = 1'b1;
        cmd_wr_o.cmd.cls = plrc_pkg::CMD_END;
      end else begin
        // remember the point; the first one only primes the segment
        prev_x_d     = in_item_i.point_x;
        prev_y_d     = in_item_i.point_y;
        seen_first_d = 1'b1;
        if (seen_first_q) begin
          cmd_wr_o.valid   = 1'b1;
          cmd_wr_o.cmd.cls = (prev_in && cur_in) ? plrc_pkg::CMD_EMIT : plrc_pkg::CMD_TEST;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q       <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      seen_first_q <= 1'b0;
    end else begin
      area_q       <= area_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      seen_first_q <= seen_first_d;
    end
  end

endmodule

@@ src/plrc_back.sv @@
// Back part: edge crossing test over four steps and result sequencing.
// Depends on plrc_pkg.
module plrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plrc_pkg::area_t   area_i,
  input  logic              cmd_valid_i,
  input  plrc_pkg::cmd_t    cmd_i,
  output logic              cmd_pop_o,
  input  logic              out_full_i,
  output plrc_pkg::out_wr_t out_wr_o,
  output logic              line_started_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam int unsigned CntW  = $clog2(plrc_pkg::NumEdges + 1);
  localparam int unsigned EdgeW = $bits(plrc_pkg::edge_e);
  localparam logic [CntW-1:0] CntLast = CntW'(plrc_pkg::NumEdges);
  localparam plrc_pkg::prod_t ProdZero = '0;

  state_e           state_q, state_d;
  plrc_pkg::cmd_t   cmd_q, cmd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             start_pend_q, start_pend_d;
  logic             two_pend_q, two_pend_d;
  logic             line_started_q, line_started_d;
  logic             fin_has_q, fin_has_d;
  plrc_pkg::coord_t fin_x_q, fin_x_d;
  plrc_pkg::coord_t fin_y_q, fin_y_d;
  plrc_pkg::prod_t  t_q, t_d, s1_q, s1_d, m1_q, m1_d, m2_q, m2_d;
  plrc_pkg::prod_t  s2;
  plrc_pkg::edge_e  edge_sel;
  plrc_pkg::coord_t corner_x, corner_y;
  plrc_pkg::diff_t  len, vx, vy, wx, wy;
  plrc_pkg::op_t    a_op, b_op;
  logic             horiz, edge_meet, final_wr;

  assign line_started_o = line_started_q;
  assign edge_sel       = plrc_pkg::edge_e'(cnt_q[EdgeW-1:0]);

  always_comb begin
    corner_x = area_i.left;
    corner_y = area_i.top;
    horiz    = 1'b1;
    len      = plrc_pkg::coord_sub(area_i.right, area_i.left);
    unique case (edge_sel)
      plrc_pkg::EDGE_TOP: begin
        corner_x = area_i.left;
        corner_y = area_i.top;
        horiz    = 1'b1;
        len      = plrc_pkg::coord_sub(area_i.right, area_i.left);
      end
      plrc_pkg::EDGE_RIGHT: begin
        corner_x = area_i.right;
        corner_y = area_i.top;
        horiz    = 1'b0;
        len      = plrc_pkg::coord_sub(area_i.bottom, area_i.top);
      end
      plrc_pkg::EDGE_BOTTOM: begin
        corner_x = area_i.right;
        corner_y = area_i.bottom;
        horiz    = 1'b1;
        len      = plrc_pkg::coord_sub(area_i.left, area_i.right);
      end
      plrc_pkg::EDGE_LEFT: begin
        corner_x = area_i.left;
        corner_y = area_i.bottom;
        horiz    = 1'b0;
        len      = plrc_pkg::coord_sub(area_i.top, area_i.bottom);
      end
    endcase
  end

  // axis-aligned edge: one direction component is zero, leaving four products
  always_comb begin
    vx   = plrc_pkg::coord_sub(cmd_q.cur_x, cmd_q.prev_x);
    vy   = plrc_pkg::coord_sub(cmd_q.cur_y, cmd_q.prev_y);
    wx   = plrc_pkg::coord_sub(corner_x, cmd_q.prev_x);
    wy   = plrc_pkg::coord_sub(corner_y, cmd_q.prev_y);
    a_op = horiz ? plrc_pkg::op_t'(vy) : -plrc_pkg::op_t'(vx);
    b_op = horiz ? -plrc_pkg::op_t'(wy) : plrc_pkg::op_t'(wx);
    t_d  = plrc_pkg::prod_t'(len) * plrc_pkg::prod_t'(a_op);
    s1_d = plrc_pkg::prod_t'(len) * plrc_pkg::prod_t'(b_op);
    m1_d = plrc_pkg::prod_t'(wx) * plrc_pkg::prod_t'(vy);
    m2_d = plrc_pkg::prod_t'(vx) * plrc_pkg::prod_t'(wy);
  end

  always_comb begin
    s2 = m1_q - m2_q;
    priority if (t_q > ProdZero) begin
      edge_meet = (s1_q >= ProdZero) && (s1_q <= t_q) && (s2 >= ProdZero) && (s2 <= t_q);
    end else if (t_q < ProdZero) begin
      edge_meet = (s1_q <= ProdZero) && (s1_q >= t_q) && (s2 <= ProdZero) && (s2 >= t_q);
    end else begin
      edge_meet = (s1_q == ProdZero) || (s2 == ProdZero);
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    cnt_d          = cnt_q;
    start_pend_d   = start_pend_q;
    two_pend_d     = two_pend_q;
    line_started_d = line_started_q;
    fin_has_d      = fin_has_q;
    fin_x_d        = fin_x_q;
    fin_y_d        = fin_y_q;
    out_wr_o       = '0;
    final_wr       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_CALC: begin
        cnt_d = cnt_q + 1'b1;
        if ((cnt_q != '0) && edge_meet) begin
          state_d      = ST_EMIT;
          start_pend_d = !line_started_q;
          two_pend_d   = 1'b1;
          fin_has_d    = 1'b1;
          fin_x_d      = cmd_q.cur_x;
          fin_y_d      = cmd_q.cur_y;
        end else if (cnt_q == CntLast) begin
          // drop: no edge crossed
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_full_i) begin
          out_wr_o.valid = 1'b1;
          if (start_pend_q) begin
            out_wr_o.item.event_kind = plrc_pkg::EVT_START;
            start_pend_d             = 1'b0;
            line_started_d           = 1'b1;
          end else if (two_pend_q) begin
            out_wr_o.item.event_kind = plrc_pkg::EVT_APPEND;
            out_wr_o.item.has_point  = 1'b1;
            out_wr_o.item.out_x      = cmd_q.prev_x;
            out_wr_o.item.out_y      = cmd_q.prev_y;
            two_pend_d               = 1'b0;
          end else begin
            out_wr_o.item.event_kind = plrc_pkg::EVT_APPEND;
            out_wr_o.item.has_point  = fin_has_q;
            out_wr_o.item.out_x      = fin_x_q;
            out_wr_o.item.out_y      = fin_y_q;
            out_wr_o.item.last       = 1'b1;
            final_wr                 = 1'b1;
            state_d                  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // take the next request alongside the final result of this one
    cmd_pop_o = cmd_valid_i && ((state_q == ST_IDLE) || final_wr);
    if (cmd_pop_o) begin
      cmd_d        = cmd_i;
      cnt_d        = '0;
      start_pend_d = !line_started_q;
      two_pend_d   = 1'b0;
      unique case (cmd_i.cls)
        plrc_pkg::CMD_END: begin
          state_d   = ST_EMIT;
          fin_has_d = cmd_i.has_prev;
          fin_x_d   = cmd_i.has_prev ? cmd_i.prev_x : '0;
          fin_y_d   = cmd_i.has_prev ? cmd_i.prev_y : '0;
        end
        plrc_pkg::CMD_EMIT: begin
          state_d   = ST_EMIT;
          fin_has_d = 1'b1;
          fin_x_d   = cmd_i.cur_x;
          fin_y_d   = cmd_i.cur_y;
        end
        plrc_pkg::CMD_TEST: state_d = ST_CALC;
        default:            state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      start_pend_q   <= 1'b0;
      two_pend_q     <= 1'b0;
      line_started_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      cnt_q          <= cnt_d;
      start_pend_q   <= start_pend_d;
      two_pend_q     <= two_pend_d;
      line_started_q <= line_started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    fin_has_q <= fin_has_d;
    fin_x_q   <= fin_x_d;
    fin_y_q   <= fin_y_d;
    if (state_q == ST_CALC) begin
      t_q  <= t_d;
      s1_q <= s1_d;
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
  end

endmodule

@@ verif/polyline_rect_clip_filter_test.sv @@
// Self-checking testbench for polyline_rect_clip_filter: drives track points and end requests,
// predicts the clipped event stream and compares every popped result with the prediction.
// Depends on plrc_pkg and the polyline_rect_clip_filter RTL; needs nothing else.
module polyline_rect_clip_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plrc_pkg::*;

  localparam longint CoordMin   = -(longint'(1) << (CoordW - 1));
  localparam longint CoordMax   = (longint'(1) << (CoordW - 1)) - 1;
  localparam int     DrainCycles = 20;
  localparam int     CycleLimit  = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item_i = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_LEFT;
  coord_t     cfg_data_i = '0;

  in_item_t  pending_reqs[$];
  out_item_t expected_events[$];
  out_item_t staged_events[$];

  area_t  area_cfg = '0;
  coord_t track_prev_x = '0;
  coord_t track_prev_y = '0;
  bit     track_has_point = 1'b0;
  bit     line_open = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  polyline_rect_clip_filter u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic bit point_in_area(coord_t x, coord_t y);
    return longint'(x) >= longint'(area_cfg.left) && longint'(x) <= longint'(area_cfg.right) &&
           longint'(y) >= longint'(area_cfg.top) && longint'(y) <= longint'(area_cfg.bottom);
  endfunction

  function automatic bit segment_meets_edge(longint p1x, longint p1y, longint p2x, longint p2y,
                                            longint q1x, longint q1y, longint q2x, longint q2y);
    longint ux, uy, vx, vy, wx, wy, t, s1, s2;
    ux = p2x - p1x;
    uy = p2y - p1y;
    vx = q2x - q1x;
    vy = q2y - q1y;
    wx = p1x - q1x;
    wy = p1y - q1y;
    t  = ux * vy - vx * uy;
    s1 = wx * uy - ux * wy;
    s2 = wx * vy - vx * wy;
    if (t > 0) return s1 >= 0 && s1 <= t && s2 >= 0 && s2 <= t;
    if (t < 0) return s1 <= 0 && s1 >= t && s2 <= 0 && s2 >= t;
    return s1 == 0 || s2 == 0;
  endfunction

  function automatic void stage_append(bit has, coord_t x, coord_t y);
    out_item_t ev;
    if (!line_open) begin
      ev = '0;
      ev.event_kind = EVT_START;
      staged_events.push_back(ev);
      line_open = 1'b1;
    end
    ev = '0;
    ev.event_kind = EVT_APPEND;
    ev.has_point = has;
    if (has) begin
      ev.out_x = x;
      ev.out_y = y;
    end
    staged_events.push_back(ev);
  endfunction

  function automatic void predict_events(in_item_t req);
    longint l, t, r, b, px, py, cx, cy;
    staged_events.delete();
    l  = longint'(area_cfg.left);
    t  = longint'(area_cfg.top);
    r  = longint'(area_cfg.right);
    b  = longint'(area_cfg.bottom);
    px = longint'(track_prev_x);
    py = longint'(track_prev_y);
    cx = longint'(req.point_x);
    cy = longint'(req.point_y);
    if (req.req_type == REQ_END) begin
      stage_append(track_has_point, track_prev_x, track_prev_y);
    end else begin
      if (track_has_point) begin
        if (point_in_area(track_prev_x, track_prev_y) &&
            point_in_area(req.point_x, req.point_y)) begin
          stage_append(1'b1, req.point_x, req.point_y);
        end else if (segment_meets_edge(l, t, r, t, px, py, cx, cy) ||
                     segment_meets_edge(r, t, r, b, px, py, cx, cy) ||
                     segment_meets_edge(r, b, l, b, px, py, cx, cy) ||
                     segment_meets_edge(l, b, l, t, px, py, cx, cy)) begin
          stage_append(1'b1, track_prev_x, track_prev_y);
          stage_append(1'b1, req.point_x, req.point_y);
        end
      end
      track_has_point = 1'b1;
      track_prev_x = req.point_x;
      track_prev_y = req.point_y;
    end
    if (staged_events.size() != 0) staged_events[staged_events.size() - 1].last = 1'b1;
    foreach (staged_events[i]) expected_events.push_back(staged_events[i]);
  endfunction

  function automatic coord_t pick_coord(coord_t lo, coord_t hi);
    longint a, b, span, v;
    a = (longint'(lo) < longint'(hi)) ? longint'(lo) : longint'(hi);
    b = (longint'(lo) < longint'(hi)) ? longint'(hi) : longint'(lo);
    span = b - a + 1;
    case ($urandom_range(0, 9))
      0: v = longint'(coord_t'($urandom()));
      1: v = $urandom_range(0, 1) ? CoordMin : CoordMax;
      2, 3: v = ($urandom_range(0, 1) ? a : b) + longint'($urandom_range(0, 2)) - 1;
      default: v = a - span / 2 + longint'($urandom_range(0, 32'(span * 2)));
    endcase
    if (v < CoordMin) v = CoordMin;
    if (v > CoordMax) v = CoordMax;
    return coord_t'(v);
  endfunction

  task automatic queue_req(req_type_e kind, int x, int y);
    in_item_t req;
    req.req_type = kind;
    req.point_x = coord_t'(x);
    req.point_y = coord_t'(y);
    pending_reqs.push_back(req);
  endtask

  task automatic queue_random_reqs(int count);
    in_item_t req;
    repeat (count) begin
      req.req_type = ($urandom_range(0, 99) < 8) ? REQ_END : REQ_PUSH;
      req.point_x = pick_coord(area_cfg.left, area_cfg.right);
      req.point_y = pick_coord(area_cfg.top, area_cfg.bottom);
      pending_reqs.push_back(req);
    end
  endtask

  // hold until every request is taken and every result has been popped, then let the pipe empty
  task automatic wait_until_idle();
    while (pending_reqs.size() != 0 || expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_area_reg(reg_idx_e idx, int value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= coord_t'(value);
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LEFT:   area_cfg.left   = coord_t'(value);
      REG_TOP:    area_cfg.top    = coord_t'(value);
      REG_RIGHT:  area_cfg.right  = coord_t'(value);
      REG_BOTTOM: area_cfg.bottom = coord_t'(value);
      default: ;
    endcase
  endtask

  task automatic set_area(int l, int t, int r, int b);
    write_area_reg(REG_LEFT, l);
    write_area_reg(REG_TOP, t);
    write_area_reg(REG_RIGHT, r);
    write_area_reg(REG_BOTTOM, b);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) predict_events(pending_reqs.pop_front());
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        in_item_i <= pending_reqs[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result at cycle %0d: kind %0d has %0b x %0d y %0d last %0b",
                     cycle_count, out_item_o.event_kind, out_item_o.has_point,
                     out_item_o.out_x, out_item_o.out_y, out_item_o.last);
        end else begin
          if (out_item_o.event_kind !== expected_events[0].event_kind ||
              out_item_o.has_point !== expected_events[0].has_point ||
              out_item_o.out_x !== expected_events[0].out_x ||
              out_item_o.out_y !== expected_events[0].out_y ||
              out_item_o.last !== expected_events[0].last) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch at cycle %0d: expected kind %0d has %0b x %0d y %0d last %0b,%s",
                       cycle_count, expected_events[0].event_kind, expected_events[0].has_point,
                       expected_events[0].out_x, expected_events[0].out_y,
                       expected_events[0].last, "");
            if (error_count <= 10)
              $display("  got kind %0d has %0b x %0d y %0d last %0b",
                       out_item_o.event_kind, out_item_o.has_point,
                       out_item_o.out_x, out_item_o.out_y, out_item_o.last);
          end
          void'(expected_events.pop_front());
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int lx, ty;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 13;
    recv_idle_pct = 54;

    // end request before any point, with the reset rectangle
    queue_req(REQ_END, 0, 0);
    wait_until_idle();

    set_area(-100, -50, 200, 150);
    queue_req(REQ_PUSH, 0, 0);
    queue_req(REQ_PUSH, 50, 50);
    queue_req(REQ_PUSH, 300, 50);
    queue_req(REQ_PUSH, 400, 60);
    queue_req(REQ_PUSH, -300, 60);
    queue_req(REQ_PUSH, -200, -50);
    queue_req(REQ_PUSH, 300, -50);
    queue_req(REQ_PUSH, -100, 150);
    queue_req(REQ_PUSH, -100, -50);
    queue_req(REQ_PUSH, 8388607, 8388607);
    queue_req(REQ_PUSH, -8388608, -8388608);
    queue_req(REQ_PUSH, -8388608, 8388607);
    queue_req(REQ_PUSH, 8388607, -8388608);
    queue_req(REQ_END, -1, -1);
    queue_req(REQ_PUSH, 10, 10);
    queue_req(REQ_END, 0, 0);
    queue_req(REQ_END, 0, 0);
    queue_req(REQ_PUSH, 500, 160);
    queue_req(REQ_PUSH, 600, 160);
    wait_until_idle();

    // swapped horizontal bounds
    set_area(100, -50, -100, 150);
    queue_req(REQ_PUSH, 0, 0);
    queue_req(REQ_PUSH, 0, 20);
    queue_req(REQ_PUSH, 100, -50);
    queue_req(REQ_END, 0, 0);
    wait_until_idle();

    lx = int'($urandom_range(0, 8000)) - 4000;
    ty = int'($urandom_range(0, 8000)) - 4000;
    set_area(lx, ty, lx + int'($urandom_range(1, 3000)), ty + int'($urandom_range(1, 3000)));
    queue_random_reqs(33);
    wait_until_idle();
    queue_random_reqs(32);
    wait_until_idle();

    send_idle_pct = 54;
    recv_idle_pct = 13;
    set_area(-8388608, -8388608, 8388607, 8388607);
    queue_random_reqs(65);
    wait_until_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_area(8388607, -8388608, -8388608, 8388607);
    queue_random_reqs(65);
    wait_until_idle();

    lx = 8388607 - int'($urandom_range(1, 2000));
    set_area(lx, -8388608, 8388607, -8388608 + int'($urandom_range(1, 2000)));
    queue_random_reqs(65);
    wait_until_idle();

    if (error_count == 0 && expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/plrc_pkg.sv
src/plrc_fifo.sv
src/plrc_front.sv
src/plrc_back.sv
src/polyline_rect_clip_filter.sv
verif/polyline_rect_clip_filter_test.sv
